[rtl/core/smm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and codes for the scaled matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package smm_pkg;

    // Operation codes carried by a request
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_LOAD_C  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    // Register indexes on the configuration port (paddr[2])
    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_BETA  = 1'b1;

    localparam logic signed [15:0] ALPHA_RESET = 16'sd16384;
    localparam logic signed [15:0] BETA_RESET  = 16'sd9830;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [15:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         out_row;
        logic [3:0]         out_col;
        logic signed [15:0] out_value;
        logic               saturated;
    } out_item_t;

    // Tags that travel with the store read data into the MAC unit
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // Finished element from the MAC unit
    typedef struct packed {
        logic               done;
        logic signed [15:0] value;
        logic               saturated;
    } mac_res_t;

endpackage
`default_nettype wire

[rtl/core/smm_mac_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smm_mac_unit
// Multiply-accumulate over one row/column pair stream, then scale by alpha
// and beta, add, and saturate to Q1.15.
// ----------------------------------------------------------------------------
module smm_mac_unit #(
    parameter int MATRIX_DIM = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire smm_pkg::mac_ctl_t  ctl,
    input  wire logic signed [15:0] a_data,
    input  wire logic signed [15:0] b_data,
    input  wire logic signed [15:0] c_data,
    input  wire logic signed [15:0] alpha,
    input  wire logic signed [15:0] beta,
    output smm_pkg::mac_res_t       res
);

    localparam int SUM_W = 32 + $clog2(MATRIX_DIM);
    localparam int SA_W  = SUM_W + 16;
    localparam int SH_W  = SA_W - 30;
    localparam int TOT_W = SUM_W - 12;

    logic signed [31:0]    prod_reg;
    logic                  p_valid_reg;
    logic                  p_first_reg;
    logic                  p_last_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic                  sum_done_reg;
    logic signed [SA_W-1:0] sa_reg;
    logic signed [31:0]    cb_reg;
    logic                  scaled_reg;
    logic signed [15:0]    value_reg;
    logic                  sat_reg;
    logic                  done_reg;

    logic signed [SUM_W-1:0] prod_ext;
    logic signed [SH_W-1:0]  sa_sh;
    logic signed [16:0]      cb_sh;
    logic signed [TOT_W-1:0] total;
    logic signed [TOT_W-1:0] max_v;
    logic signed [TOT_W-1:0] min_v;
    logic signed [15:0]      value_next;
    logic                    sat_next;

    assign prod_ext = {{(SUM_W-32){prod_reg[31]}}, prod_reg};
    assign max_v    = TOT_W'(32767);
    assign min_v    = -TOT_W'(32768);

    // Arithmetic shifts by dropping low bits (floor)
    always_comb
    begin
        sa_sh = sa_reg[SA_W-1:30];
        cb_sh = cb_reg[31:15];
        total = {{(TOT_W-SH_W){sa_sh[SH_W-1]}}, sa_sh}
              + {{(TOT_W-17){cb_sh[16]}}, cb_sh};
        priority if (total > max_v)
        begin
            value_next = 16'sh7fff;
            sat_next   = 1'b1;
        end
        else if (total < min_v)
        begin
            value_next = 16'sh8000;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = total[15:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            p_first_reg  <= 1'b0;
            p_last_reg   <= 1'b0;
            sum_done_reg <= 1'b0;
            scaled_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            p_valid_reg  <= ctl.valid;
            p_first_reg  <= ctl.valid & ctl.first;
            p_last_reg   <= ctl.valid & ctl.last;
            sum_done_reg <= p_valid_reg & p_last_reg;
            scaled_reg   <= sum_done_reg;
            done_reg     <= scaled_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prod_reg <= a_data * b_data;
        end
        if (p_valid_reg)
        begin
            // restart the sum on the first pair
            acc_reg <= p_first_reg ? prod_ext : acc_reg + prod_ext;
        end
        if (sum_done_reg)
        begin
            sa_reg <= acc_reg * alpha;
            cb_reg <= c_data * beta;
        end
        if (scaled_reg)
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign res.done      = done_reg;
    assign res.value     = value_reg;
    assign res.saturated = sat_reg;

endmodule
`default_nettype wire

[rtl/core/scaled_matrix_multiply_accumulate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_accumulate
// C = alpha*A*B + beta*C in Q1.15, with A, B and C held in on-chip stores.
// ----------------------------------------------------------------------------
// A load request gives no result. A compute request reads its row and column
// from the A and B stores and its element from the C store; A and B each have
// one read port, so the row and column are streamed one pair per cycle into
// the multiply-accumulate, followed by product, accumulate, scale, saturate
// and write-back stages. A finished result waits in the output register while
// the block takes further requests; a compute that finishes before that result
// is taken holds until the output register frees. Requests with a row or column
// not below MATRIX_DIM are taken and dropped. Every element must be loaded
// before a compute reads it. The stores need no clearing after reset.
// ----------------------------------------------------------------------------
module scaled_matrix_multiply_accumulate #(
    parameter int MATRIX_DIM = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire smm_pkg::in_item_t in_data,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output smm_pkg::out_item_t     out_data,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int DEPTH = MATRIX_DIM * MATRIX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MATRIX_DIM);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_WAIT   = 4'b0100,
        S_RETIRE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] mem_a [DEPTH];
    logic signed [15:0] mem_b [DEPTH];
    logic signed [15:0] mem_c [DEPTH];

    logic signed [15:0] alpha_reg;
    logic signed [15:0] beta_reg;
    logic [KW-1:0]      k_reg;
    logic [3:0]         row_reg;
    logic [3:0]         col_reg;
    logic signed [15:0] a_rdata_reg;
    logic signed [15:0] b_rdata_reg;
    logic signed [15:0] c_rdata_reg;
    smm_pkg::mac_ctl_t  ctl_reg;
    smm_pkg::mac_res_t  res;
    logic               out_valid_reg;
    smm_pkg::out_item_t out_data_reg;

    logic          accept;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] c_addr;
    logic [AW-1:0] a_raddr;
    logic [AW-1:0] b_raddr;
    logic          k_last;
    logic          out_free;
    logic          retire;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == smm_pkg::REG_BETA) ? {{16{beta_reg[15]}}, beta_reg}
                                                       : {{16{alpha_reg[15]}}, alpha_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= smm_pkg::ALPHA_RESET;
            beta_reg  <= smm_pkg::BETA_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                smm_pkg::REG_ALPHA: alpha_reg <= pwdata[15:0];
                smm_pkg::REG_BETA:  beta_reg  <= pwdata[15:0];
                default:            alpha_reg <= alpha_reg;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid & ~in_stall;
    assign in_range = (int'(in_data.row_index) < MATRIX_DIM)
                    && (int'(in_data.col_index) < MATRIX_DIM);
    assign in_addr  = AW'(int'(in_data.row_index) * MATRIX_DIM + int'(in_data.col_index));
    assign c_addr   = AW'(int'(row_reg) * MATRIX_DIM + int'(col_reg));
    assign a_raddr  = AW'(int'(row_reg) * MATRIX_DIM + int'(k_reg));
    assign b_raddr  = AW'(int'(k_reg) * MATRIX_DIM + int'(col_reg));
    assign k_last   = (k_reg == KW'(MATRIX_DIM - 1));
    assign out_free = ~out_valid_reg | ~out_stall;
    assign retire   = (state_reg == S_RETIRE) & out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_range && in_data.operation == smm_pkg::OP_COMPUTE)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (k_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (res.done)
                begin
                    state_next = S_RETIRE;
                end
            end
            S_RETIRE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            ctl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_READ)
            begin
                k_reg <= k_last ? '0 : k_reg + 1'b1;
            end
            ctl_reg.valid <= (state_reg == S_READ);
            ctl_reg.first <= (k_reg == '0);
            ctl_reg.last  <= k_last;
            if (retire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= in_data.row_index;
            col_reg <= in_data.col_index;
        end
        if (retire)
        begin
            out_data_reg.out_row   <= row_reg;
            out_data_reg.out_col   <= col_reg;
            out_data_reg.out_value <= res.value;
            out_data_reg.saturated <= res.saturated;
        end
    end

    // A store: written by loads, read along the row
    always_ff @(posedge clk)
    begin
        if (accept && in_range && in_data.operation == smm_pkg::OP_LOAD_A)
        begin
            mem_a[in_addr] <= in_data.element_value;
        end
        a_rdata_reg <= mem_a[a_raddr];
    end

    // B store: written by loads, read down the column
    always_ff @(posedge clk)
    begin
        if (accept && in_range && in_data.operation == smm_pkg::OP_LOAD_B)
        begin
            mem_b[in_addr] <= in_data.element_value;
        end
        b_rdata_reg <= mem_b[b_raddr];
    end

    // C store: written by loads and by the write-back of a computed element
    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            mem_c[c_addr] <= res.value;
        end
        else if (accept && in_range && in_data.operation == smm_pkg::OP_LOAD_C)
        begin
            mem_c[in_addr] <= in_data.element_value;
        end
        c_rdata_reg <= mem_c[c_addr];
    end

    smm_mac_unit #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_reg),
        .a_data (a_rdata_reg),
        .b_data (b_rdata_reg),
        .c_data (c_rdata_reg),
        .alpha  (alpha_reg),
        .beta   (beta_reg),
        .res    (res)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire
